[hdl/nct_pkg.sv]
// Package for the checked numeric type converter: type codes and the
// float packing and leading-zero helpers used by the datapath.
// No dependencies.
package nct_pkg;

    // element type codes, as written to the type registers
    localparam logic [2:0] TY_I32 = 3'd0;
    localparam logic [2:0] TY_U32 = 3'd1;
    localparam logic [2:0] TY_I64 = 3'd2;
    localparam logic [2:0] TY_U64 = 3'd3;
    localparam logic [2:0] TY_F32 = 3'd4;
    localparam logic [2:0] TY_F64 = 3'd5;

    // configuration register indexes
    localparam logic CFG_SRC = 1'b0;
    localparam logic CFG_DST = 1'b1;

    // normalized source value: value = norm * 2^(exp - 63), norm[63] set unless zero
    typedef struct packed {
        logic               sgn;
        logic signed [12:0] exp;
        logic [63:0]        norm;
        logic               zero;
        logic               inf;
        logic               nan;
    } t_unpk;

    // leading zero count of a 64-bit word (63 for zero, caller checks zero)
    function automatic logic [5:0] lzc64(input logic [63:0] n);
        logic [5:0] lz;
        lz = 6'd63;
        for (int i = 0; i < 64; i++) begin
            if (n[i]) begin
                lz = 6'(63 - i);
            end
        end
        return lz;
    endfunction

    // round a normalized nonzero value to binary32, nearest even
    function automatic logic [31:0] pack_f32(input logic sgn, input logic signed [12:0] e,
                                             input logic [63:0] n);
        logic [12:0] d;
        logic [12:0] base;
        logic [63:0] ns;
        logic        stk;
        logic [23:0] kept;
        logic        g;
        logic        s;
        logic        rup;
        logic [24:0] sum;
        logic [35:0] t;
        // subnormal range shifts right below the minimum exponent
        if (e < -13'sd126) begin
            d    = 13'(-13'sd126 - e);
            base = 13'd0;
        end else begin
            d    = 13'd0;
            base = 13'(e + 13'sd126);
        end
        if (d >= 13'd64) begin
            ns  = 64'd0;
            stk = |n;
        end else begin
            ns  = n >> d[5:0];
            stk = |(n & ((64'd1 << d[5:0]) - 64'd1));
        end
        kept = ns[63:40];
        g    = ns[39];
        s    = (|ns[38:0]) | stk;
        rup  = g & (s | kept[0]);
        sum  = {1'b0, kept} + {24'd0, rup};
        // hidden bit and rounding carry fold into the exponent field
        t = {base, 23'd0} + {11'd0, sum};
        if (t >= 36'h07F800000) begin
            t = 36'h07F800000;
        end
        return {sgn, t[30:0]};
    endfunction

    // round a normalized nonzero value to binary64, nearest even (no subnormal range)
    function automatic logic [63:0] pack_f64(input logic sgn, input logic signed [12:0] e,
                                             input logic [63:0] n);
        logic [10:0] base;
        logic [52:0] kept;
        logic        g;
        logic        s;
        logic        rup;
        logic [53:0] sum;
        logic [63:0] t;
        base = 11'(e + 13'sd1022);
        kept = n[63:11];
        g    = n[10];
        s    = |n[9:0];
        rup  = g & (s | kept[0]);
        sum  = {1'b0, kept} + {53'd0, rup};
        t    = {1'b0, base, 52'd0} + {10'd0, sum};
        return {sgn, t[62:0]};
    endfunction

endpackage

[hdl/numeric_type_cast_checked_core.sv]
// Checked numeric type converter top level.
// Depends on nct_pkg for type codes, float packing and leading-zero count.

// One element enters per cycle whenever start is high; busy is always low.
// Each element passes the input register, normalize stage and round/range
// stage, its result marked by o_valid for one cycle; the receiver cannot
// stall. Throughput is one transaction per clock. Types come from the two
// type registers; the user must write them only while idle (not enforced).
module numeric_type_cast_checked_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_value_in,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [2:0]  i_cfg_data,
    output logic        o_valid,
    output logic [63:0] o_value_out,
    output logic        o_cast_ok
);

    logic [2:0]  r_src_type;
    logic [2:0]  r_dst_type;
    logic        r_v0;
    logic [63:0] r_raw0;
    logic        r_v1;
    logic [63:0] r_raw1;
    nct_pkg::t_unpk r_unpk;
    nct_pkg::t_unpk n_unpk;
    logic [63:0] n_value;
    logic        n_ok;

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_type <= nct_pkg::TY_I32;
            r_dst_type <= nct_pkg::TY_I32;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == nct_pkg::CFG_SRC) begin
                r_src_type <= i_cfg_data;
            end else begin
                r_dst_type <= i_cfg_data;
            end
        end
    end

    // unpack the source into sign, exponent and normalized significand
    always_comb begin
        logic [63:0]        m;
        logic signed [12:0] eb;
        logic [5:0]         lz;
        logic [7:0]         ex8;
        logic [10:0]        ex11;
        m     = 64'd0;
        eb    = 13'sd0;
        ex8   = r_raw0[30:23];
        ex11  = r_raw0[62:52];
        n_unpk = '0;
        case (r_src_type)
            nct_pkg::TY_I32: begin
                n_unpk.sgn = r_raw0[31];
                m = r_raw0[31] ? {32'd0, 32'd0 - r_raw0[31:0]} : {32'd0, r_raw0[31:0]};
            end
            nct_pkg::TY_U32: begin
                m = {32'd0, r_raw0[31:0]};
            end
            nct_pkg::TY_I64: begin
                n_unpk.sgn = r_raw0[63];
                m = r_raw0[63] ? 64'd0 - r_raw0 : r_raw0;
            end
            nct_pkg::TY_U64: begin
                m = r_raw0;
            end
            nct_pkg::TY_F32: begin
                n_unpk.sgn = r_raw0[31];
                n_unpk.inf = (ex8 == 8'hFF) && (r_raw0[22:0] == 23'd0);
                n_unpk.nan = (ex8 == 8'hFF) && (r_raw0[22:0] != 23'd0);
                m  = {ex8 != 8'd0, r_raw0[22:0], 40'd0};
                eb = $signed({5'd0, (ex8 == 8'd0) ? 8'd1 : ex8}) - 13'sd190;
            end
            nct_pkg::TY_F64: begin
                n_unpk.sgn = r_raw0[63];
                n_unpk.inf = (ex11 == 11'h7FF) && (r_raw0[51:0] == 52'd0);
                n_unpk.nan = (ex11 == 11'h7FF) && (r_raw0[51:0] != 52'd0);
                m  = {ex11 != 11'd0, r_raw0[51:0], 11'd0};
                eb = $signed({2'd0, (ex11 == 11'd0) ? 11'd1 : ex11}) - 13'sd1086;
            end
            default: begin
                m = 64'd0;
            end
        endcase
        lz = nct_pkg::lzc64(m);
        n_unpk.zero = (m == 64'd0);
        n_unpk.norm = m << lz;
        n_unpk.exp  = eb + 13'sd63 - $signed({7'd0, lz});
    end

    // convert the normalized value to the destination type
    always_comb begin
        logic               fsrc;
        logic               supp;
        logic [12:0]        shf;
        logic [5:0]         sh;
        logic [63:0]        mag;
        logic               frac;
        logic               ovf;
        logic [64:0]        ceil;
        logic               nz;
        fsrc = (r_src_type == nct_pkg::TY_F32) || (r_src_type == nct_pkg::TY_F64);
        supp = (r_src_type <= nct_pkg::TY_F64) && (r_dst_type <= nct_pkg::TY_F64);
        shf  = 13'(13'sd63 - r_unpk.exp);
        sh   = shf[5:0];
        ovf  = r_unpk.exp > 13'sd63;
        if (r_unpk.exp < 13'sd0) begin
            mag  = 64'd0;
            frac = !r_unpk.zero;
        end else begin
            mag  = r_unpk.norm >> sh;
            frac = |(r_unpk.norm & ((64'd1 << sh) - 64'd1));
        end
        ceil    = {1'b0, mag} + {64'd0, frac};
        nz      = (mag != 64'd0) || frac;
        n_value = 64'd0;
        n_ok    = 1'b0;
        if (!supp) begin
            n_ok = 1'b0;
        end else if (r_src_type == r_dst_type) begin
            n_ok = 1'b1;
            if ((r_src_type == nct_pkg::TY_F64) || (r_src_type == nct_pkg::TY_I64) ||
                (r_src_type == nct_pkg::TY_U64)) begin
                n_value = r_raw1;
            end else begin
                n_value = {32'd0, r_raw1[31:0]};
            end
        end else begin
            case (r_dst_type)
                nct_pkg::TY_I32: begin
                    n_ok = !(r_unpk.nan || r_unpk.inf || ovf) &&
                           (r_unpk.sgn ? (ceil <= 65'h080000000) : (ceil <= 65'h07FFFFFFF));
                    n_value = {32'd0, r_unpk.sgn ? 32'd0 - mag[31:0] : mag[31:0]};
                end
                nct_pkg::TY_U32: begin
                    n_ok = !(r_unpk.nan || r_unpk.inf || ovf) && !(r_unpk.sgn && nz) &&
                           (ceil <= 65'h0FFFFFFFF);
                    n_value = {32'd0, mag[31:0]};
                end
                nct_pkg::TY_I64: begin
                    n_ok = !(r_unpk.nan || r_unpk.inf || ovf) &&
                           (r_unpk.sgn ? (ceil <= 65'h08000000000000000) : !mag[63]);
                    n_value = r_unpk.sgn ? 64'd0 - mag : mag;
                end
                nct_pkg::TY_U64: begin
                    n_ok = !(r_unpk.nan || r_unpk.inf || ovf) && !(r_unpk.sgn && nz);
                    n_value = mag;
                end
                nct_pkg::TY_F32: begin
                    n_ok = 1'b1;
                    if (fsrc && r_unpk.nan) begin
                        n_value = {32'd0, r_raw1[63], 8'hFF, 1'b1 | r_raw1[51], r_raw1[50:29]};
                    end else if (r_unpk.inf) begin
                        n_value = {32'd0, r_unpk.sgn, 8'hFF, 23'd0};
                    end else if (r_unpk.zero) begin
                        n_value = {32'd0, r_unpk.sgn, 31'd0};
                    end else begin
                        n_value = {32'd0,
                                   nct_pkg::pack_f32(r_unpk.sgn, r_unpk.exp, r_unpk.norm)};
                    end
                end
                nct_pkg::TY_F64: begin
                    n_ok = 1'b1;
                    if (fsrc && r_unpk.nan) begin
                        n_value = {r_raw1[31], 11'h7FF, 1'b1 | r_raw1[22], r_raw1[21:0],
                                   29'd0};
                    end else if (r_unpk.inf) begin
                        n_value = {r_unpk.sgn, 11'h7FF, 52'd0};
                    end else if (r_unpk.zero) begin
                        n_value = {r_unpk.sgn, 63'd0};
                    end else begin
                        n_value = nct_pkg::pack_f64(r_unpk.sgn, r_unpk.exp, r_unpk.norm);
                    end
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
        if (!n_ok) begin
            n_value = 64'd0;
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v0    <= start;
            r_v1    <= r_v0;
            o_valid <= r_v1;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_raw0      <= i_value_in;
        r_raw1      <= r_raw0;
        r_unpk      <= n_unpk;
        o_value_out <= n_value;
        o_cast_ok   <= n_ok;
    end

endmodule

[bench/numeric_type_cast_checked_core_test.sv]
// Self-checking bench for numeric_type_cast_checked_core: directed and random
// casts between type pairs, each result checked against an integer-only predictor.
// Depends on nct_pkg for the type codes and register indexes.
`timescale 1ns / 100ps

module numeric_type_cast_checked_core_test;

    localparam int CYCLE_LIMIT = 200000;

    // unsupported type codes
    localparam logic [2:0] TY_RSV6 = 3'd6;
    localparam logic [2:0] TY_RSV7 = 3'd7;

    typedef enum logic [1:0] {EV_ELEM, EV_CFG, EV_DRAIN, EV_IDLE} t_ev_kind;

    typedef struct {
        t_ev_kind    kind;
        logic [63:0] val;
        logic        idx;
        logic [2:0]  data;
    } t_stim;

    typedef struct {
        logic [63:0] val;
        logic        ok;
    } t_cast;

    // unpacked operand: value = m * 2^e, with sign and class flags
    typedef struct {
        logic        sgn;
        logic        zro;
        logic        inf;
        logic        nan;
        longint      e;
        logic [63:0] m;
    } t_num;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] i_value_in = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [2:0]  i_cfg_data = '0;
    logic        o_valid;
    logic [63:0] o_value_out;
    logic        o_cast_ok;

    t_stim       stim_q[$];
    t_cast       expected_casts[$];
    logic [2:0]  shadow_src = nct_pkg::TY_I32;
    logic [2:0]  shadow_dst = nct_pkg::TY_I32;
    int          idle_pct = 0;
    int          mismatches = 0;
    int          cycles = 0;

    numeric_type_cast_checked_core dut (.*);

    always #5 i_clk = ~i_clk;

    // split raw bits of the source type into sign, magnitude and exponent
    function automatic t_num unpack_src(logic [2:0] st, logic [63:0] v);
        t_num n;
        n = '{sgn: 1'b0, zro: 1'b0, inf: 1'b0, nan: 1'b0, e: 0, m: 64'd0};
        case (st)
            nct_pkg::TY_I32: begin
                n.sgn = v[31];
                n.m = {32'd0, v[31] ? (~v[31:0] + 32'd1) : v[31:0]};
            end
            nct_pkg::TY_U32: n.m = {32'd0, v[31:0]};
            nct_pkg::TY_I64: begin
                n.sgn = v[63];
                n.m = v[63] ? (~v + 64'd1) : v;
            end
            nct_pkg::TY_U64: n.m = v;
            nct_pkg::TY_F32: begin
                n.sgn = v[31];
                if (v[30:23] == 8'hFF) begin
                    n.nan = v[22:0] != 0;
                    n.inf = v[22:0] == 0;
                end else if (v[30:23] == 0) begin
                    n.m = {41'd0, v[22:0]};
                    n.e = -149;
                end else begin
                    n.m = {40'd0, 1'b1, v[22:0]};
                    n.e = longint'(v[30:23]) - 150;
                end
            end
            default: begin
                n.sgn = v[63];
                if (v[62:52] == 11'h7FF) begin
                    n.nan = v[51:0] != 0;
                    n.inf = v[51:0] == 0;
                end else if (v[62:52] == 0) begin
                    n.m = {12'd0, v[51:0]};
                    n.e = -1074;
                end else begin
                    n.m = {11'd0, 1'b1, v[51:0]};
                    n.e = longint'(v[62:52]) - 1075;
                end
            end
        endcase
        if (!n.nan && !n.inf) n.zro = n.m == 0;
        return n;
    endfunction

    // truncate toward zero into an integer type, range checked on the exact value
    function automatic t_cast to_integer(t_num n, logic [2:0] tt);
        t_cast       r;
        logic [127:0] wide;
        logic [63:0] mag;
        logic [63:0] lim;
        logic        frac;
        logic        big;
        logic        nar;
        logic        sgd;
        r = '{val: 64'd0, ok: 1'b0};
        nar = (tt == nct_pkg::TY_I32) || (tt == nct_pkg::TY_U32);
        sgd = (tt == nct_pkg::TY_I32) || (tt == nct_pkg::TY_I64);
        if (n.nan || n.inf) return r;
        if (n.zro) begin
            r.ok = 1'b1;
            return r;
        end
        big = 1'b0;
        frac = 1'b0;
        mag = 64'd0;
        if (n.e >= 64) begin
            big = 1'b1;
        end else if (n.e >= 0) begin
            wide = {64'd0, n.m} << n.e;
            big = wide[127:64] != 0;
            mag = wide[63:0];
        end else if (n.e <= -64) begin
            frac = 1'b1;
        end else begin
            wide = {n.m, 64'd0} >> (-n.e);
            mag = wide[127:64];
            frac = wide[63:0] != 0;
        end
        if (sgd) lim = nar ? 64'h7FFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
        else lim = nar ? 64'hFFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFFF;
        // negative signed values may reach one past the positive bound
        if (sgd && n.sgn) lim = lim + 64'd1;
        if (big || mag > lim || (mag == lim && frac)) return r;
        if (!sgd && n.sgn && (mag != 0 || frac)) return r;
        r.ok = 1'b1;
        r.val = n.sgn ? (~mag + 64'd1) : mag;
        if (nar) r.val[63:32] = 32'd0;
        return r;
    endfunction

    // round to nearest even into binary32 or binary64
    function automatic logic [63:0] to_float(t_num n, logic wide64);
        int           prec;
        longint       emin;
        longint       emax;
        longint       msb;
        longint       ex;
        longint       sh;
        logic [127:0] x;
        logic [63:0]  kept;
        logic [63:0]  bits;
        logic [63:0]  infpat;
        logic         g;
        logic         stk;
        prec = wide64 ? 53 : 24;
        emin = wide64 ? -1022 : -126;
        emax = wide64 ? 1023 : 127;
        infpat = 64'(emax - emin + 2) << (prec - 1);
        bits = 64'd0;
        msb = 0;
        if (n.inf) begin
            bits = infpat;
        end else if (!n.zro) begin
            for (int i = 0; i < 64; i++) if (n.m[i]) msb = i;
            if (msb + n.e > emax) begin
                bits = infpat;
            end else begin
                ex = (msb + n.e < emin) ? emin : msb + n.e;
                sh = ex - (prec - 1) - n.e;
                g = 1'b0;
                stk = 1'b0;
                if (sh <= 0) begin
                    kept = n.m << (-sh);
                end else if (sh > 128) begin
                    kept = 64'd0;
                end else begin
                    x = {n.m, 64'd0} >> sh;
                    kept = x[127:64];
                    g = x[63];
                    stk = x[62:0] != 0;
                end
                if (g && (stk || kept[0])) kept = kept + 64'd1;
                bits = (64'(ex - emin) << (prec - 1)) + kept;
                if (bits >= infpat) bits = infpat;
            end
        end
        return wide64 ? {n.sgn, bits[62:0]} : {32'd0, n.sgn, bits[30:0]};
    endfunction

    // expected result of one cast under the given type registers
    function automatic t_cast predict_cast(logic [2:0] st, logic [2:0] tt, logic [63:0] v);
        t_cast r;
        t_num  n;
        r = '{val: 64'd0, ok: 1'b0};
        if (st > nct_pkg::TY_F64 || tt > nct_pkg::TY_F64) return r;
        r.ok = 1'b1;
        if (st == tt) begin
            r.val = (st == nct_pkg::TY_I64 || st == nct_pkg::TY_U64 || st == nct_pkg::TY_F64)
                    ? v : {32'd0, v[31:0]};
            return r;
        end
        n = unpack_src(st, v);
        if (tt <= nct_pkg::TY_U64) begin
            r = to_integer(n, tt);
        end else if (n.nan && tt == nct_pkg::TY_F64) begin
            // quiet the nan, payload moves to the top of the wider fraction
            r.val = {v[31], 12'hFFF, v[21:0], 29'd0};
        end else if (n.nan) begin
            r.val = {32'd0, v[63], 9'h1FF, v[50:29]};
        end else begin
            r.val = to_float(n, tt == nct_pkg::TY_F64);
        end
        if (!r.ok) r.val = 64'd0;
        return r;
    endfunction

    // random raw value biased toward range edges and float classes
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        logic [63:0] bnd[8];
        bnd = '{64'h0, 64'h7FFF_FFFF, 64'h8000_0000, 64'hFFFF_FFFF,
                64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_8000_0000};
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v = bnd[$urandom_range(7)];
            1: v = bnd[$urandom_range(7)] + 64'($urandom_range(4)) - 64'd2;
            2: begin
                v[30:23] = ($urandom_range(3) == 0) ? 8'($urandom_range(1) * 255)
                                                    : 8'($urandom_range(196, 125));
                if ($urandom_range(3) == 0) v[22:0] = $urandom_range(1) ? '1 : '0;
            end
            3: begin
                case ($urandom_range(3))
                    0: v[62:52] = 11'($urandom_range(1) * 2047);
                    1: v[62:52] = 11'($urandom_range(1090, 1021));
                    2: v[62:52] = 11'($urandom_range(1151, 1100));
                    default: v[62:52] = 11'($urandom_range(930, 840));
                endcase
                if ($urandom_range(3) == 0) v[51:0] = $urandom_range(1) ? '1 : '0;
            end
            4: v = 64'($signed($urandom_range(200)) - 100);
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_cfg(logic [2:0] st, logic [2:0] tt);
        stim_q.push_back('{kind: EV_CFG, val: 64'd0, idx: nct_pkg::CFG_SRC, data: st});
        stim_q.push_back('{kind: EV_CFG, val: 64'd0, idx: nct_pkg::CFG_DST, data: tt});
    endtask

    task automatic add_elem(logic [63:0] v);
        stim_q.push_back('{kind: EV_ELEM, val: v, idx: 1'b0, data: 3'd0});
    endtask

    task automatic add_idle(int pct);
        stim_q.push_back('{kind: EV_IDLE, val: 64'd0, idx: 1'b0, data: 3'(pct)});
        stim_q[$].val = 64'(pct);
    endtask

    // driver: offers transactions and predicts each accepted one
    always @(posedge i_clk) begin
        logic        nxt_start;
        logic        nxt_we;
        logic [63:0] nxt_val;
        logic        nxt_idx;
        logic [2:0]  nxt_data;
        nxt_start = 1'b0;
        nxt_we = 1'b0;
        nxt_val = i_value_in;
        nxt_idx = i_cfg_idx;
        nxt_data = i_cfg_data;
        if (i_rst_n) begin
            if (start && !busy)
                expected_casts.push_back(predict_cast(shadow_src, shadow_dst, i_value_in));
            if (start && busy) begin
                nxt_start = 1'b1;
            end else if (stim_q.size() > 0) begin
                case (stim_q[0].kind)
                    EV_ELEM: begin
                        if ($urandom_range(99) >= idle_pct) begin
                            nxt_start = 1'b1;
                            nxt_val = stim_q[0].val;
                            void'(stim_q.pop_front());
                        end
                    end
                    EV_CFG: begin
                        if (expected_casts.size() == 0 && !start) begin
                            nxt_we = 1'b1;
                            nxt_idx = stim_q[0].idx;
                            nxt_data = stim_q[0].data;
                            if (stim_q[0].idx == nct_pkg::CFG_SRC) shadow_src = stim_q[0].data;
                            else shadow_dst = stim_q[0].data;
                            void'(stim_q.pop_front());
                        end
                    end
                    EV_DRAIN: begin
                        if (expected_casts.size() == 0 && !start) void'(stim_q.pop_front());
                    end
                    default: begin
                        idle_pct = int'(stim_q[0].val);
                        void'(stim_q.pop_front());
                    end
                endcase
            end
        end
        start <= nxt_start;
        i_cfg_we <= nxt_we;
        i_value_in <= nxt_val;
        i_cfg_idx <= nxt_idx;
        i_cfg_data <= nxt_data;
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_cast exp_c;
        if (i_rst_n && o_valid) begin
            if (expected_casts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value_out=%h cast_ok=%b", o_value_out, o_cast_ok);
            end else begin
                exp_c = expected_casts.pop_front();
                if (exp_c.val !== o_value_out || exp_c.ok !== o_cast_ok) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: value_out exp %h got %h, cast_ok exp %b got %b",
                                 exp_c.val, o_value_out, exp_c.ok, o_cast_ok);
                end
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("numeric_type_cast_checked_core_test failed");
            $finish;
        end
    end

    initial begin
        logic [2:0] st;
        logic [2:0] tt;
        // directed: range edges, narrow sources, nan, rounding, unsupported codes
        add_cfg(nct_pkg::TY_I32, nct_pkg::TY_U32);
        add_elem(64'hFFFF_FFFF_8000_0000);
        add_elem(64'hABCD_0000_7FFF_FFFF);
        add_cfg(nct_pkg::TY_I64, nct_pkg::TY_I32);
        add_elem(64'hFFFF_FFFF_8000_0000);
        add_elem(64'hFFFF_FFFF_7FFF_FFFF);
        add_cfg(nct_pkg::TY_F32, nct_pkg::TY_U32);
        add_elem(64'h0000_0000_BF00_0000);
        add_elem(64'h0000_0000_8000_0000);
        add_elem(64'h0000_0000_7FC0_0001);
        add_cfg(nct_pkg::TY_F64, nct_pkg::TY_F32);
        add_elem(64'hFFF0_0000_1234_5678);
        add_elem(64'h47F0_0000_0000_0000);
        add_elem(64'h3690_0000_0000_0001);
        add_cfg(nct_pkg::TY_F32, nct_pkg::TY_F64);
        add_elem(64'h0000_0000_7F80_0001);
        add_elem(64'h0000_0000_0000_0001);
        add_cfg(nct_pkg::TY_U64, nct_pkg::TY_F32);
        add_elem(64'hFFFF_FFFF_FFFF_FFFF);
        add_cfg(nct_pkg::TY_I64, nct_pkg::TY_F64);
        add_elem(64'h8000_0000_0000_0000);
        add_cfg(nct_pkg::TY_F64, nct_pkg::TY_I64);
        add_elem(64'hC3E0_0000_0000_0000);
        add_elem(64'h43E0_0000_0000_0000);
        add_cfg(nct_pkg::TY_F64, nct_pkg::TY_U64);
        add_elem(64'h43EF_FFFF_FFFF_FFFF);
        add_cfg(TY_RSV6, TY_RSV6);
        add_elem(64'h1);
        add_cfg(nct_pkg::TY_U32, nct_pkg::TY_U32);
        add_elem(64'hFFFF_FFFF_FFFF_FFFF);
        add_cfg(nct_pkg::TY_F64, nct_pkg::TY_F64);
        add_elem(64'hFFF8_0000_0000_0001);
        add_cfg(nct_pkg::TY_U64, TY_RSV7);
        add_elem(64'h5);
        // random phases: sender idles rarely, then often, then never
        for (int ph = 0; ph < 3; ph++) begin
            add_idle(ph == 0 ? 22 : (ph == 1 ? 77 : 0));
            for (int blk = 0; blk < 9; blk++) begin
                st = 3'($urandom_range(7));
                tt = 3'($urandom_range(7));
                if ($urandom_range(7) != 0) begin
                    st = 3'($urandom_range(5));
                    tt = 3'($urandom_range(5));
                end
                if (blk == 0) begin
                    st = ph == 1 ? TY_RSV7 : nct_pkg::TY_F64;
                    tt = ph == 1 ? TY_RSV7 : nct_pkg::TY_I32;
                end
                add_cfg(st, tt);
                for (int k = 0; k < 15; k++) begin
                    add_elem(pick_value());
                    // hold off once until the pipeline is empty
                    if (ph == 0 && blk == 4 && k == 7)
                        stim_q.push_back('{kind: EV_DRAIN, val: 64'd0, idx: 1'b0, data: 3'd0});
                end
            end
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (stim_q.size() > 0 || expected_casts.size() > 0 || start) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_casts.size() == 0)
            $display("numeric_type_cast_checked_core_test passed");
        else
            $display("numeric_type_cast_checked_core_test failed");
        $finish;
    end

endmodule

[numeric_type_cast_checked_core.f]
hdl/nct_pkg.sv
hdl/numeric_type_cast_checked_core.sv
bench/numeric_type_cast_checked_core_test.sv
